[src/gsol_pkg.sv]
// ----------------------------------------------------------------------------
// gsol_pkg
// Shared types, constants, the Q1.14 sine table and the sequencer program
// of the gimbal scan obstacle locator.
// ----------------------------------------------------------------------------
package gsol_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_HOR_MIN        = 3'd0;
    localparam logic [2:0] REG_HOR_MAX        = 3'd1;
    localparam logic [2:0] REG_VER_MIN        = 3'd2;
    localparam logic [2:0] REG_VER_MAX        = 3'd3;
    localparam logic [2:0] REG_ANGLE_STEP     = 3'd4;
    localparam logic [2:0] REG_NEAR_THRESHOLD = 3'd5;

    // register reset values
    localparam logic [7:0]  HOR_MIN_RST   = 8'd0;
    localparam logic [7:0]  HOR_MAX_RST   = 8'd180;
    localparam logic [7:0]  VER_MIN_RST   = 8'd0;
    localparam logic [7:0]  VER_MAX_RST   = 8'd180;
    localparam logic [6:0]  STEP_RST      = 7'd5;
    localparam logic [14:0] THRESHOLD_RST = 15'd1600;

    // echo time to 1/16 cm: (t * RANGE_SCALE) >> RANGE_SHIFT
    localparam logic signed [15:0] RANGE_SCALE = 16'sd1114;
    localparam int unsigned        RANGE_SHIFT = 12;
    localparam logic [7:0]         HALF_TURN   = 8'd180;
    localparam logic [7:0]         QUARTER     = 8'd90;

    // sequencer step addresses
    localparam logic [2:0] STEP_IDLE  = 3'd0;
    localparam logic [2:0] STEP_RANGE = 3'd1;
    localparam logic [2:0] STEP_Z     = 3'd2;
    localparam logic [2:0] STEP_PROJ  = 3'd3;
    localparam logic [2:0] STEP_Y     = 3'd4;
    localparam logic [2:0] STEP_X     = 3'd5;
    localparam logic [2:0] STEP_DONE  = 3'd6;

    // round(16384 * sin(deg)) for 0..90 degrees
    localparam logic [14:0] SIN_Q14 [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    typedef struct packed {
        logic signed [15:0] s;
        logic signed [15:0] c;
    } trig_t;

    // multiplier operand selects and result destinations
    typedef enum logic [1:0] {
        OPA_ECHO,
        OPA_RANGE,
        OPA_PROJ
    } opa_t;

    typedef enum logic [2:0] {
        OPB_SCALE,
        OPB_COS_VER,
        OPB_SIN_VER,
        OPB_SIN_HOR,
        OPB_COS_HOR
    } opb_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_RANGE,
        DST_Z,
        DST_PROJ,
        DST_Y,
        DST_X
    } dst_t;

    // condition that lets the sequencer leave a step
    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_IN_BEAT,
        COND_OUT_FREE
    } cond_t;

    typedef struct packed {
        cond_t      cond;
        logic       jump;
        logic [2:0] target;
        logic       load_trig;
        opa_t       opa;
        opb_t       opb;
        dst_t       dst;
        logic       finish;
    } uop_t;

    // sine and cosine of a whole-degree angle, angles above 180 mirrored
    function automatic trig_t trig(input logic [7:0] a);
        logic        neg;
        logic [7:0]  ar;
        logic [7:0]  i_s;
        logic [7:0]  i_c;
        logic        c_neg;
        logic signed [15:0] s;
        logic signed [15:0] c;
        trig_t       r;
        neg = (a > HALF_TURN);
        ar  = neg ? (a - HALF_TURN) : a;
        if (ar <= QUARTER)
        begin
            i_s   = ar;
            i_c   = QUARTER - ar;
            c_neg = 1'b0;
        end
        else
        begin
            i_s   = HALF_TURN - ar;
            i_c   = ar - QUARTER;
            c_neg = 1'b1;
        end
        s = signed'({1'b0, SIN_Q14[i_s[6:0]]});
        c = signed'({1'b0, SIN_Q14[i_c[6:0]]});
        if (c_neg)
        begin
            c = -c;
        end
        if (neg)
        begin
            s = -s;
            c = -c;
        end
        r.s = s;
        r.c = c;
        return r;
    endfunction

    // control store: one word per step
    function automatic uop_t ucode(input logic [2:0] pc);
        uop_t u;
        u = '{cond: COND_ALWAYS, jump: 1'b0, target: STEP_IDLE, load_trig: 1'b0,
              opa: OPA_ECHO, opb: OPB_SCALE, dst: DST_NONE, finish: 1'b0};
        unique case (pc)
            STEP_IDLE:
            begin
                u.cond = COND_IN_BEAT;
            end
            STEP_RANGE:
            begin
                u.load_trig = 1'b1;
                u.opa       = OPA_ECHO;
                u.opb       = OPB_SCALE;
                u.dst       = DST_RANGE;
            end
            STEP_Z:
            begin
                u.opa = OPA_RANGE;
                u.opb = OPB_COS_VER;
                u.dst = DST_Z;
            end
            STEP_PROJ:
            begin
                u.opa = OPA_RANGE;
                u.opb = OPB_SIN_VER;
                u.dst = DST_PROJ;
            end
            STEP_Y:
            begin
                u.opa = OPA_PROJ;
                u.opb = OPB_SIN_HOR;
                u.dst = DST_Y;
            end
            STEP_X:
            begin
                u.opa = OPA_PROJ;
                u.opb = OPB_COS_HOR;
                u.dst = DST_X;
            end
            STEP_DONE:
            begin
                u.cond   = COND_OUT_FREE;
                u.jump   = 1'b1;
                u.target = STEP_IDLE;
                u.finish = 1'b1;
            end
            default:
            begin
                u.jump   = 1'b1;
                u.target = STEP_IDLE;
            end
        endcase
        return u;
    endfunction

endpackage

[src/gimbal_scan_obstacle_locator_unit.sv]
// ----------------------------------------------------------------------------
// gimbal_scan_obstacle_locator_unit
// Turns one ultrasonic echo time per gimbal point into range, x/y/z parts
// and near flags, and keeps the two-axis sweep position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one echo_time_us per beat.
//   Output channel (out_valid / out_stall) carries one result per input
//   beat: the angles of the point, the range, the three components, their
//   near flags and sweep_end on the last point of a full sweep.
//   Config port: cfg_write with cfg_index / cfg_data, written while idle;
//   any write restarts the sweep at the lower limits.
// Timing:
//   A microcoded sequencer runs seven steps per item over one shared
//   17x16 multiplier: wait, range, z, projection, y, x, finish. The result
//   is registered in the finish step and the next item is taken in the
//   wait step after it, so items go through the sequencer one at a time.
//   The output register frees the sequencer, which can take the next
//   input while a result still waits; a stalled result holds the finish
//   step until it is taken.
// Reset:
//   Registers take their default values, the sweep restarts at the lower
//   limits and both channels are empty.
// ----------------------------------------------------------------------------
module gimbal_scan_obstacle_locator_unit
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [14:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [15:0]        echo_time_us,

    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         hor_angle,
    output logic [7:0]         ver_angle,
    output logic [14:0]        range_sixteenths,
    output logic signed [15:0] x_part,
    output logic signed [15:0] y_part,
    output logic signed [15:0] z_part,
    output logic               x_near,
    output logic               y_near,
    output logic               z_near,
    output logic               sweep_end
);

    // configuration and control state
    logic [7:0]  hor_min_reg;
    logic [7:0]  hor_max_reg;
    logic [7:0]  ver_min_reg;
    logic [7:0]  ver_max_reg;
    logic [6:0]  step_reg;
    logic [14:0] thr_reg;
    logic        running_reg;
    logic [2:0]  pc_reg;
    logic [2:0]  pc_next;
    logic        out_valid_reg;

    // datapath registers
    logic [15:0]        echo_reg;
    logic [7:0]         cur_hor_reg;
    logic [7:0]         cur_ver_reg;
    logic [7:0]         cur_hor_next;
    logic [7:0]         cur_ver_next;
    gsol_pkg::trig_t    ver_trig_reg;
    gsol_pkg::trig_t    hor_trig_reg;
    logic [14:0]        range_reg;
    logic signed [15:0] z_reg;
    logic signed [15:0] proj_reg;
    logic signed [15:0] y_reg;
    logic signed [15:0] x_reg;

    // output register
    logic [7:0]         o_hor_reg;
    logic [7:0]         o_ver_reg;
    logic [14:0]        o_range_reg;
    logic signed [15:0] o_x_reg;
    logic signed [15:0] o_y_reg;
    logic signed [15:0] o_z_reg;
    logic               o_xn_reg;
    logic               o_yn_reg;
    logic               o_zn_reg;
    logic               o_end_reg;

    gsol_pkg::uop_t     uop;
    logic               in_beat;
    logic               out_beat;
    logic               proceed;
    logic               do_finish;
    logic signed [16:0] mul_a;
    logic signed [15:0] mul_b;
    logic signed [32:0] prod;
    logic signed [32:0] prod_rnd;
    logic [15:0]        prod_q;
    logic [6:0]         step_eff;
    logic [8:0]         hor_sum;
    logic [8:0]         ver_sum;
    logic               hor_wrap;
    logic               ver_wrap;
    logic signed [16:0] thr_s;
    logic               x_lt;
    logic               y_lt;
    logic               z_lt;

    // control word of the current step
    assign uop      = gsol_pkg::ucode(pc_reg);
    assign in_stall = (uop.cond != gsol_pkg::COND_IN_BEAT);
    assign in_beat  = in_valid && !in_stall;
    assign out_beat = out_valid_reg && !out_stall;

    // step exit condition and next step
    always_comb
    begin
        unique case (uop.cond)
            gsol_pkg::COND_IN_BEAT:  proceed = in_valid;
            gsol_pkg::COND_OUT_FREE: proceed = !out_valid_reg || !out_stall;
            gsol_pkg::COND_ALWAYS:   proceed = 1'b1;
            default:                 proceed = 1'b1;
        endcase
        if (!proceed)
        begin
            pc_next = pc_reg;
        end
        else if (uop.jump)
        begin
            pc_next = uop.target;
        end
        else
        begin
            pc_next = pc_reg + 3'd1;
        end
    end

    assign do_finish = uop.finish && proceed;

    // shared multiplier operands
    always_comb
    begin
        unique case (uop.opa)
            gsol_pkg::OPA_ECHO:  mul_a = signed'({1'b0, echo_reg});
            gsol_pkg::OPA_RANGE: mul_a = signed'({2'b00, range_reg});
            gsol_pkg::OPA_PROJ:  mul_a = {proj_reg[15], proj_reg};
            default:             mul_a = signed'({1'b0, echo_reg});
        endcase
        unique case (uop.opb)
            gsol_pkg::OPB_SCALE:   mul_b = gsol_pkg::RANGE_SCALE;
            gsol_pkg::OPB_COS_VER: mul_b = ver_trig_reg.c;
            gsol_pkg::OPB_SIN_VER: mul_b = ver_trig_reg.s;
            gsol_pkg::OPB_SIN_HOR: mul_b = hor_trig_reg.s;
            gsol_pkg::OPB_COS_HOR: mul_b = hor_trig_reg.c;
            default:               mul_b = gsol_pkg::RANGE_SCALE;
        endcase
    end

    // product and Q1.14 rounding, ties toward plus infinity
    assign prod     = mul_a * mul_b;
    assign prod_rnd = prod + 33'sd8192;
    assign prod_q   = prod_rnd[29:14];

    // sweep stepping
    assign step_eff = (step_reg == 7'd0) ? 7'd1 : step_reg;
    assign hor_sum  = {1'b0, cur_hor_reg} + {2'b00, step_eff};
    assign ver_sum  = {1'b0, cur_ver_reg} + {2'b00, step_eff};
    assign hor_wrap = (hor_min_reg > hor_max_reg) || (hor_sum > {1'b0, hor_max_reg});
    assign ver_wrap = (ver_min_reg > ver_max_reg) || (ver_sum > {1'b0, ver_max_reg});

    always_comb
    begin
        cur_hor_next = cur_hor_reg;
        cur_ver_next = cur_ver_reg;
        if (in_beat && !running_reg)
        begin
            cur_hor_next = hor_min_reg;
            cur_ver_next = ver_min_reg;
        end
        else if (do_finish)
        begin
            cur_hor_next = hor_wrap ? hor_min_reg : hor_sum[7:0];
            if (hor_wrap)
            begin
                cur_ver_next = ver_wrap ? ver_min_reg : ver_sum[7:0];
            end
        end
    end

    // signed compares against the threshold
    assign thr_s = signed'({2'b00, thr_reg});
    assign x_lt  = signed'({x_reg[15], x_reg}) < thr_s;
    assign y_lt  = signed'({y_reg[15], y_reg}) < thr_s;
    assign z_lt  = signed'({z_reg[15], z_reg}) < thr_s;

    // control state, configuration and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hor_min_reg   <= gsol_pkg::HOR_MIN_RST;
            hor_max_reg   <= gsol_pkg::HOR_MAX_RST;
            ver_min_reg   <= gsol_pkg::VER_MIN_RST;
            ver_max_reg   <= gsol_pkg::VER_MAX_RST;
            step_reg      <= gsol_pkg::STEP_RST;
            thr_reg       <= gsol_pkg::THRESHOLD_RST;
            running_reg   <= 1'b0;
            pc_reg        <= gsol_pkg::STEP_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg <= pc_next;
            if (do_finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_beat)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                running_reg <= 1'b0;
                unique case (cfg_index)
                    gsol_pkg::REG_HOR_MIN:        hor_min_reg <= cfg_data[7:0];
                    gsol_pkg::REG_HOR_MAX:        hor_max_reg <= cfg_data[7:0];
                    gsol_pkg::REG_VER_MIN:        ver_min_reg <= cfg_data[7:0];
                    gsol_pkg::REG_VER_MAX:        ver_max_reg <= cfg_data[7:0];
                    gsol_pkg::REG_ANGLE_STEP:     step_reg    <= cfg_data[6:0];
                    gsol_pkg::REG_NEAR_THRESHOLD: thr_reg     <= cfg_data;
                    default:                      ;
                endcase
            end
            else if (in_beat)
            begin
                running_reg <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        cur_hor_reg <= cur_hor_next;
        cur_ver_reg <= cur_ver_next;
        if (in_beat)
        begin
            echo_reg <= echo_time_us;
        end
        if (uop.load_trig)
        begin
            ver_trig_reg <= gsol_pkg::trig(cur_ver_reg);
            hor_trig_reg <= gsol_pkg::trig(cur_hor_reg);
        end
        unique case (uop.dst)
            gsol_pkg::DST_RANGE: range_reg <= prod[gsol_pkg::RANGE_SHIFT +: 15];
            gsol_pkg::DST_Z:     z_reg     <= prod_q;
            gsol_pkg::DST_PROJ:  proj_reg  <= prod_q;
            gsol_pkg::DST_Y:     y_reg     <= prod_q;
            gsol_pkg::DST_X:     x_reg     <= prod_q;
            gsol_pkg::DST_NONE:  ;
            default:             ;
        endcase
        // result beat, taken before the sweep advances
        if (do_finish)
        begin
            o_hor_reg   <= cur_hor_reg;
            o_ver_reg   <= cur_ver_reg;
            o_range_reg <= range_reg;
            o_x_reg     <= x_reg;
            o_y_reg     <= y_reg;
            o_z_reg     <= z_reg;
            o_xn_reg    <= x_lt;
            o_yn_reg    <= y_lt;
            o_zn_reg    <= z_lt;
            o_end_reg   <= hor_wrap && ver_wrap;
        end
    end

    assign out_valid        = out_valid_reg;
    assign hor_angle        = o_hor_reg;
    assign ver_angle        = o_ver_reg;
    assign range_sixteenths = o_range_reg;
    assign x_part           = o_x_reg;
    assign y_part           = o_y_reg;
    assign z_part           = o_z_reg;
    assign x_near           = o_xn_reg;
    assign y_near           = o_yn_reg;
    assign z_near           = o_zn_reg;
    assign sweep_end        = o_end_reg;

    // an accepted beat always starts the range step next cycle
    a_beat_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> (pc_reg == gsol_pkg::STEP_RANGE))
        else $error("sequencer did not start after input beat");

    // negative components always carry their near flag
    a_neg_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (x_part[15] || y_part[15] || z_part[15]) |->
            ((!x_part[15] || x_near) && (!y_part[15] || y_near)
             && (!z_part[15] || z_near)))
        else $error("negative component without near flag");

    // a configuration write restarts the sweep
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !running_reg)
        else $error("sweep still running after configuration write");

    // a pending result is never overwritten while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !do_finish)
        else $error("result overwritten while stalled");

endmodule

[tb/sv/gimbal_scan_obstacle_locator_unit_test.sv]
// ----------------------------------------------------------------------------
// gimbal_scan_obstacle_locator_unit_test
// Self-checking bench for the gimbal scan obstacle locator. Echo times go in
// one beat at a time. A local model of the sweep position and the fixed-point
// range/trig math predicts each result beat, and the results are checked
// field by field in order. Directed cases cover the reset sweep, angles past
// 180, inverted limits, a zero step and restarts on register writes. Random
// sweeps, random idling on both channels and one long output hold follow.
// ----------------------------------------------------------------------------
module gimbal_scan_obstacle_locator_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    // register indexes past the list, any write still restarts the sweep
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int LONG_HOLD    = 300;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANGE_MUL    = 1114;

    typedef struct {
        logic [7:0]  hor;
        logic [7:0]  ver;
        logic [14:0] range;
        int          x;
        int          y;
        int          z;
        bit          x_flag;
        bit          y_flag;
        bit          z_flag;
        bit          last;
    } scan_point_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [14:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [15:0]        echo_time_us;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         hor_angle;
    logic [7:0]         ver_angle;
    logic [14:0]        range_sixteenths;
    logic signed [15:0] x_part;
    logic signed [15:0] y_part;
    logic signed [15:0] z_part;
    logic               x_near;
    logic               y_near;
    logic               z_near;
    logic               sweep_end;

    // round(16384 * sin(deg)) for 0..90 degrees
    int sine_table [0:90] = '{
        0, 286, 572, 857, 1143, 1428, 1713, 1997, 2280, 2563,
        2845, 3126, 3406, 3686, 3964, 4240, 4516, 4790, 5063, 5334,
        5604, 5872, 6138, 6402, 6664, 6924, 7182, 7438, 7692, 7943,
        8192, 8438, 8682, 8923, 9162, 9397, 9630, 9860, 10087, 10311,
        10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
        12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
        14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
        15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
        16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
        16384
    };

    // predicted register and sweep state
    int cfg_hor_min;
    int cfg_hor_max;
    int cfg_ver_min;
    int cfg_ver_max;
    int cfg_step;
    int cfg_threshold;
    int sweep_hor;
    int sweep_ver;
    bit sweep_live;

    scan_point_t pending_points [$];
    int          fails = 0;
    bit          src_idle_on = 1'b1;
    bit          sink_idle_on = 1'b1;
    bit          hold_request = 1'b0;

    gimbal_scan_obstacle_locator_unit dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .echo_time_us     (echo_time_us),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .hor_angle        (hor_angle),
        .ver_angle        (ver_angle),
        .range_sixteenths (range_sixteenths),
        .x_part           (x_part),
        .y_part           (y_part),
        .z_part           (z_part),
        .x_near           (x_near),
        .y_near           (y_near),
        .z_near           (z_near),
        .sweep_end        (sweep_end)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // q1.14 sine and cosine, angles past 180 mirrored with a sign flip
    function automatic void trig_q14(input int angle, output int s, output int c);
        int a;
        bit flip;
        a = angle & 255;
        flip = 1'b0;
        if (a > 180)
        begin
            a -= 180;
            flip = 1'b1;
        end
        if (a <= 90)
        begin
            s = sine_table[a];
            c = sine_table[90 - a];
        end
        else
        begin
            s = sine_table[180 - a];
            c = -sine_table[a - 90];
        end
        if (flip)
        begin
            s = -s;
            c = -c;
        end
    endfunction

    // product with a q1.14 factor, rounded half up
    function automatic int round_q14(input int v, input int q);
        longint p;
        p = longint'(v) * longint'(q) + 64'sd8192;
        return int'(p >>> 14);
    endfunction

    // one axis step, returns 1 when the axis wraps to its low limit
    function automatic bit advance_axis(inout int cur, input int lo, input int hi,
                                        input int stp);
        if (lo > hi || cur + stp > hi)
        begin
            cur = lo;
            return 1'b1;
        end
        cur += stp;
        return 1'b0;
    endfunction

    // expected point for one echo beat, moves the sweep on
    task automatic locate_point(input logic [15:0] echo, output scan_point_t pt);
        int t;
        int stp;
        int range;
        int sv;
        int cv;
        int sh;
        int ch;
        int proj;
        t   = echo;
        stp = (cfg_step == 0) ? 1 : cfg_step;
        if (!sweep_live)
        begin
            sweep_hor  = cfg_hor_min;
            sweep_ver  = cfg_ver_min;
            sweep_live = 1'b1;
        end
        range = (t * RANGE_MUL) >> gsol_pkg::RANGE_SHIFT;
        trig_q14(sweep_ver, sv, cv);
        trig_q14(sweep_hor, sh, ch);
        pt.z      = round_q14(range, cv);
        proj      = round_q14(range, sv);
        pt.y      = round_q14(proj, sh);
        pt.x      = round_q14(proj, ch);
        pt.hor    = sweep_hor[7:0];
        pt.ver    = sweep_ver[7:0];
        pt.range  = range[14:0];
        pt.x_flag = pt.x < cfg_threshold;
        pt.y_flag = pt.y < cfg_threshold;
        pt.z_flag = pt.z < cfg_threshold;
        pt.last   = 1'b0;
        if (advance_axis(sweep_hor, cfg_hor_min, cfg_hor_max, stp))
        begin
            pt.last = advance_axis(sweep_ver, cfg_ver_min, cfg_ver_max, stp);
        end
    endtask

    // one register write, mirrored into the local state
    task automatic write_reg(input logic [2:0] idx, input logic [14:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            gsol_pkg::REG_HOR_MIN:        cfg_hor_min   = data[7:0];
            gsol_pkg::REG_HOR_MAX:        cfg_hor_max   = data[7:0];
            gsol_pkg::REG_VER_MIN:        cfg_ver_min   = data[7:0];
            gsol_pkg::REG_VER_MAX:        cfg_ver_max   = data[7:0];
            gsol_pkg::REG_ANGLE_STEP:     cfg_step      = data[6:0];
            gsol_pkg::REG_NEAR_THRESHOLD: cfg_threshold = data;
            default:                      ;
        endcase
        sweep_live = 1'b0;
    endtask

    // drop valid and let every pending point drain
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (3) @(negedge clk);
    endtask

    // value in the low bits, sometimes junk above the register width
    function automatic logic [14:0] with_junk(input int val, input int bits);
        logic [14:0] upper;
        upper = ($urandom_range(0, 3) == 0) ? 15'($urandom) : 15'd0;
        upper = (upper >> bits) << bits;
        return upper | 15'(val);
    endfunction

    task automatic set_sweep(input int hmin, input int hmax, input int vmin,
                             input int vmax, input int stp, input int thr);
        wait_idle();
        write_reg(gsol_pkg::REG_HOR_MIN, with_junk(hmin, 8));
        write_reg(gsol_pkg::REG_HOR_MAX, with_junk(hmax, 8));
        write_reg(gsol_pkg::REG_VER_MIN, with_junk(vmin, 8));
        write_reg(gsol_pkg::REG_VER_MAX, with_junk(vmax, 8));
        write_reg(gsol_pkg::REG_ANGLE_STEP, with_junk(stp, 7));
        write_reg(gsol_pkg::REG_NEAR_THRESHOLD, 15'(thr));
    endtask

    // one echo beat, with an optional idle burst ahead of it
    task automatic send_echo(input logic [15:0] echo);
        int gap;
        scan_point_t pt;
        gap = (src_idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        echo_time_us <= echo;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        locate_point(echo, pt);
        pending_points.push_back(pt);
    endtask

    function automatic int rand_angle();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 180;
            2:       return $urandom_range(181, 255);
            default: return $urandom_range(0, 180);
        endcase
    endfunction

    function automatic logic [15:0] rand_echo();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 255));
            3:       return 16'($urandom_range(65000, 65535));
            default: return 16'($urandom);
        endcase
    endfunction

    // random sweep window, mostly narrow so sweeps end often
    task automatic pick_sweep();
        int hmin;
        int hmax;
        int vmin;
        int vmax;
        int stp;
        int thr;
        hmin = rand_angle();
        hmax = ($urandom_range(0, 3) == 0) ? rand_angle() : hmin + $urandom_range(0, 60);
        vmin = rand_angle();
        vmax = ($urandom_range(0, 3) == 0) ? rand_angle() : vmin + $urandom_range(0, 60);
        if (hmax > 255)
        begin
            hmax = 255;
        end
        if (vmax > 255)
        begin
            vmax = 255;
        end
        case ($urandom_range(0, 7))
            0:       stp = 0;
            1:       stp = 1;
            2:       stp = 90;
            3:       stp = $urandom_range(91, 127);
            default: stp = $urandom_range(1, 30);
        endcase
        case ($urandom_range(0, 4))
            0:       thr = 0;
            1:       thr = 32767;
            2:       thr = $urandom_range(0, 2000);
            default: thr = $urandom_range(0, 32767);
        endcase
        set_sweep(hmin, hmax, vmin, vmax, stp, thr);
    endtask

    // reset settings, timeout and echo extremes
    task automatic test_default_sweep();
        send_echo(16'd0);
        send_echo(16'hFFFF);
        send_echo(16'd1);
        send_echo(16'h8000);
        send_echo(16'h7FFF);
    endtask

    // angles past 180 and past 90, negative parts, full sweep and wrap
    task automatic test_wide_angles();
        set_sweep(95, 255, 135, 255, 80, 32767);
        repeat (7) send_echo(16'hFFFF);
    endtask

    // low limit above high limit, zero step, zero threshold
    task automatic test_inverted_limits();
        set_sweep(120, 30, 90, 90, 0, 0);
        send_echo(16'hFFFF);
        send_echo(16'd0);
        send_echo(16'd1000);
    endtask

    // writes to spare indexes restart the sweep too
    task automatic test_restart_on_write();
        set_sweep(0, 20, 0, 10, 10, 1600);
        send_echo(16'd4000);
        send_echo(16'd4000);
        wait_idle();
        write_reg(REG_SPARE_LO, 15'($urandom));
        send_echo(16'd4000);
        send_echo(16'd4000);
        wait_idle();
        write_reg(REG_SPARE_HI, 15'($urandom));
        send_echo(16'd4000);
    endtask

    task automatic test_random_sweeps();
        for (int phase = 0; phase < 10; phase++)
        begin
            src_idle_on  = $urandom_range(0, 3) != 0;
            sink_idle_on = $urandom_range(0, 3) != 0;
            pick_sweep();
            for (int n = 0; n < 100; n++)
            begin
                // occasional restart in the middle of a sweep
                if (n == 50 && $urandom_range(0, 2) == 0)
                begin
                    wait_idle();
                    write_reg(3'($urandom_range(0, 7)), 15'($urandom));
                end
                send_echo(rand_echo());
            end
        end
    endtask

    // long output hold while the input keeps offering beats
    task automatic test_backpressure();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        pick_sweep();
        hold_request = 1'b1;
        repeat (25) send_echo(rand_echo());
    endtask

    // back to back beats, no idling on either side
    task automatic test_streaming();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        pick_sweep();
        repeat (80) send_echo(rand_echo());
    endtask

    // output stall: random bursts, one long hold on request
    initial
    begin : result_sink
        int burst;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
                out_stall <= 1'b0;
                hold_request = 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    // compare each result beat with the oldest pending point
    always @(posedge clk)
    begin : result_check
        scan_point_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_points.size() == 0)
            begin
                $error("result beat with no point pending");
                fails++;
            end
            else
            begin
                want = pending_points.pop_front();
                compare_field("hor_angle", want.hor, hor_angle);
                compare_field("ver_angle", want.ver, ver_angle);
                compare_field("range_sixteenths", want.range, range_sixteenths);
                compare_field("x_part", want.x, x_part);
                compare_field("y_part", want.y, y_part);
                compare_field("z_part", want.z, z_part);
                compare_field("x_near", want.x_flag, x_near);
                compare_field("y_near", want.y_flag, y_near);
                compare_field("z_near", want.z_flag, z_near);
                compare_field("sweep_end", want.last, sweep_end);
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("gimbal_scan_obstacle_locator_unit_test NOT OK");
        $finish;
    end

    // test sequence
    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = gsol_pkg::REG_HOR_MIN;
        cfg_data     = '0;
        in_valid     = 1'b0;
        echo_time_us = '0;

        cfg_hor_min   = gsol_pkg::HOR_MIN_RST;
        cfg_hor_max   = gsol_pkg::HOR_MAX_RST;
        cfg_ver_min   = gsol_pkg::VER_MIN_RST;
        cfg_ver_max   = gsol_pkg::VER_MAX_RST;
        cfg_step      = gsol_pkg::STEP_RST;
        cfg_threshold = gsol_pkg::THRESHOLD_RST;
        sweep_hor     = 0;
        sweep_ver     = 0;
        sweep_live    = 1'b0;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_default_sweep();
        test_wide_angles();
        test_inverted_limits();
        test_restart_on_write();
        test_random_sweeps();
        test_backpressure();
        test_streaming();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0)
        begin
            $display("gimbal_scan_obstacle_locator_unit_test OK");
        end
        else
        begin
            $display("gimbal_scan_obstacle_locator_unit_test NOT OK");
        end
        $finish;
    end

endmodule
